// ----- hdl/cpl_pkg.sv -----
// Shared constants, types and register codes for the chassis current power limiter.
`default_nettype none
package cpl_pkg;

  // Field widths
  localparam int CUR_W     = 16;  // wheel current command width
  localparam int TOT_W     = 18;  // total limit width
  localparam int WHL_W     = 15;  // per-wheel limit width
  localparam int BUF_W     = 16;  // power buffer, Q12.4
  localparam int NUM_LANES = 4;

  // Datapath widths
  localparam int QB    = CUR_W;              // quotient bits (|q| <= 2^(CUR_W-1))
  localparam int SUM_W = CUR_W + 2;          // sum of four magnitudes
  localparam int NUM_W = TOT_W + CUR_W;      // total * |clamped|
  localparam int DIV_W = SUM_W + QB + 1;     // trial subtract width
  localparam int N_ST  = QB + 3;             // clamp, multiply, QB divide steps, output

  // Stream widths
  localparam int IN_W        = NUM_LANES * CUR_W + BUF_W + 2;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = NUM_LANES * CUR_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TOT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_HIGH = 3'd0,
    REG_TOTAL_MID  = 3'd1,
    REG_TOTAL_LOW  = 3'd2,
    REG_WHEEL_HIGH = 3'd3,
    REG_WHEEL_MID  = 3'd4,
    REG_WHEEL_LOW  = 3'd5
  } cfg_reg_e;

  // Buffer tier thresholds in Q12.4 (40 J, 15 J, 7 J)
  localparam logic [BUF_W-1:0] BUF_HIGH = 16'd640;
  localparam logic [BUF_W-1:0] BUF_MID  = 16'd240;
  localparam logic [BUF_W-1:0] BUF_LOW  = 16'd112;

  // Fixed limits for referee offline and boost
  localparam logic [TOT_W-1:0] OFFLINE_TOTAL = 18'd13000;
  localparam logic [WHL_W-1:0] OFFLINE_WHEEL = 15'd4500;
  localparam logic [TOT_W-1:0] BOOST_TOTAL   = 18'd25000;
  localparam logic [WHL_W-1:0] BOOST_WHEEL   = 15'd7000;

  // Register reset values
  localparam logic [TOT_W-1:0] RST_TOTAL_HIGH = 18'd20000;
  localparam logic [TOT_W-1:0] RST_TOTAL_MID  = 18'd12000;
  localparam logic [TOT_W-1:0] RST_TOTAL_LOW  = 18'd6000;
  localparam logic [WHL_W-1:0] RST_WHEEL_HIGH = 15'd6000;
  localparam logic [WHL_W-1:0] RST_WHEEL_MID  = 15'd4000;
  localparam logic [WHL_W-1:0] RST_WHEEL_LOW  = 15'd2000;

  typedef struct packed {
    logic [TOT_W-1:0] total_high;
    logic [TOT_W-1:0] total_mid;
    logic [TOT_W-1:0] total_low;
    logic [WHL_W-1:0] wheel_high;
    logic [WHL_W-1:0] wheel_mid;
    logic [WHL_W-1:0] wheel_low;
  } cfg_t;

  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [WHL_W-1:0] wheel;
  } lim_t;

endpackage
`default_nettype wire

// ----- hdl/cpl_tier_sel.sv -----
// Limit selection from buffer tier, referee offline and boost flags.
`default_nettype none
module cpl_tier_sel (
  input  wire logic [cpl_pkg::BUF_W-1:0] buffer_i,
  input  wire logic                      offline_i,
  input  wire logic                      boost_i,
  input  wire cpl_pkg::cfg_t             cfg_i,
  output cpl_pkg::lim_t                  lim_o
);

  // Boost wins over offline, offline wins over the buffer tiers
  always_comb begin
    priority if (boost_i) begin
      lim_o.total = cpl_pkg::BOOST_TOTAL;
      lim_o.wheel = cpl_pkg::BOOST_WHEEL;
    end else if (offline_i) begin
      lim_o.total = cpl_pkg::OFFLINE_TOTAL;
      lim_o.wheel = cpl_pkg::OFFLINE_WHEEL;
    end else if (buffer_i > cpl_pkg::BUF_HIGH) begin
      lim_o.total = cfg_i.total_high;
      lim_o.wheel = cfg_i.wheel_high;
    end else if (buffer_i > cpl_pkg::BUF_MID) begin
      lim_o.total = cfg_i.total_mid;
      lim_o.wheel = cfg_i.wheel_mid;
    end else if (buffer_i >= cpl_pkg::BUF_LOW) begin
      lim_o.total = cfg_i.total_low;
      lim_o.wheel = cfg_i.wheel_low;
    end else begin
      lim_o.total = '0;
      lim_o.wheel = '0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cpl_lane.sv -----
// One wheel lane: clamp, magnitude, product and bit-per-stage restoring divide.
`default_nettype none
module cpl_lane (
  input  wire logic                              clk_i,
  input  wire logic [cpl_pkg::N_ST-1:0]          ld_i,     // per-stage load enables
  input  wire logic signed [cpl_pkg::CUR_W-1:0]  cmd_i,
  input  wire logic [cpl_pkg::WHL_W-1:0]         wheel_i,
  input  wire logic [cpl_pkg::TOT_W-1:0]         tot0_i,   // total limit, stage 0
  input  wire logic [cpl_pkg::QB-1:0][cpl_pkg::SUM_W-1:0] den_i, // divisor per step
  input  wire logic                              scale_i,  // scale flag, last divide stage
  output logic [cpl_pkg::CUR_W-1:0]              mag_o,    // |unclamped cmd|, stage 0
  output logic [cpl_pkg::CUR_W-1:0]              res_o
);

  localparam int CUR_W = cpl_pkg::CUR_W;
  localparam int QB    = cpl_pkg::QB;
  localparam int NUM_W = cpl_pkg::NUM_W;
  localparam int DIV_W = cpl_pkg::DIV_W;
  localparam int N_ST  = cpl_pkg::N_ST;
  localparam int CMP_W = ((CUR_W > cpl_pkg::WHL_W) ? CUR_W : cpl_pkg::WHL_W) + 2;

  // Clamp to [-wheel, +wheel] and take magnitudes
  logic signed [CMP_W-1:0] v_ext, w_ext, c_ext;
  logic [CUR_W-1:0] mag_d, cmag_d, cl_d;

  always_comb begin
    v_ext = CMP_W'(cmd_i);
    w_ext = signed'(CMP_W'(wheel_i));
    priority if (v_ext > w_ext) begin
      c_ext = w_ext;
    end else if (v_ext < -w_ext) begin
      c_ext = -w_ext;
    end else begin
      c_ext = v_ext;
    end
    mag_d  = cmd_i[CUR_W-1] ? CUR_W'(-v_ext) : CUR_W'(v_ext);
    cmag_d = c_ext[CMP_W-1] ? CUR_W'(-c_ext) : CUR_W'(c_ext);
    cl_d   = CUR_W'(c_ext);
  end

  // Stage 0
  logic [CUR_W-1:0] mag_q, cmag_q, cl0_q;
  logic             neg0_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      mag_q  <= mag_d;
      cmag_q <= cmag_d;
      cl0_q  <= cl_d;
      neg0_q <= cmd_i[CUR_W-1];
    end
  end

  assign mag_o = mag_q;

  // Stage 1: total * |clamped|
  logic [NUM_W-1:0] prod_q;
  logic [CUR_W-1:0] cl1_q;
  logic             neg1_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      prod_q <= NUM_W'(tot0_i) * NUM_W'(cmag_q);
      cl1_q  <= cl0_q;
      neg1_q <= neg0_q;
    end
  end

  // Divide stages: one quotient bit each, most significant first
  logic [NUM_W-1:0] rem_q [QB];
  logic [QB-1:0]    quo_q [QB];
  logic [CUR_W-1:0] cld_q [QB];
  logic             ngd_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;

    logic [NUM_W-1:0] rem_src, rem_d;
    logic [QB-1:0]    quo_src, quo_d;
    logic [CUR_W-1:0] cl_src;
    logic             ng_src;
    logic [DIV_W-1:0] num_w, den_w;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_src = prod_q;
      assign quo_src = '0;
      assign cl_src  = cl1_q;
      assign ng_src  = neg1_q;
    end else begin : g_next
      assign rem_src = rem_q[j-1];
      assign quo_src = quo_q[j-1];
      assign cl_src  = cld_q[j-1];
      assign ng_src  = ngd_q[j-1];
    end

    always_comb begin
      num_w     = DIV_W'(rem_src);
      den_w     = DIV_W'(den_i[j]) << SH;
      ge        = (num_w >= den_w);
      rem_d     = ge ? NUM_W'(num_w - den_w) : rem_src;
      quo_d     = quo_src;
      quo_d[SH] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (ld_i[2+j]) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        cld_q[j] <= cl_src;
        ngd_q[j] <= ng_src;
      end
    end
  end

  // Output register: restore sign of quotient, or pass clamped value
  logic [CUR_W-1:0] res_d, res_q;
  logic [CUR_W-1:0] q_mag;

  always_comb begin
    q_mag = CUR_W'(quo_q[QB-1]);
    if (scale_i) begin
      res_d = ngd_q[QB-1] ? CUR_W'(-q_mag) : q_mag;
    end else begin
      res_d = cld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[N_ST-1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ----- hdl/cpl_merge.sv -----
// Merge stage: sums lane magnitudes, compares with total, carries divisor down the pipe.
`default_nettype none
module cpl_merge (
  input  wire logic                                          clk_i,
  input  wire logic [cpl_pkg::N_ST-2:0]                      ld_i,
  input  wire logic [cpl_pkg::TOT_W-1:0]                     tot_i,
  input  wire logic [cpl_pkg::NUM_LANES-1:0][cpl_pkg::CUR_W-1:0] mag_i,
  output logic [cpl_pkg::TOT_W-1:0]                          tot0_o,
  output logic [cpl_pkg::QB-1:0][cpl_pkg::SUM_W-1:0]         den_o,
  output logic                                               scale_o
);

  localparam int QB    = cpl_pkg::QB;
  localparam int SUM_W = cpl_pkg::SUM_W;
  localparam int TOT_W = cpl_pkg::TOT_W;
  localparam int CMP_W = ((SUM_W > TOT_W) ? SUM_W : TOT_W);

  // Stage 0: total limit alongside lane clamp
  logic [TOT_W-1:0] tot0_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      tot0_q <= tot_i;
    end
  end

  assign tot0_o = tot0_q;

  // Stage 1: sum of unclamped magnitudes
  logic [SUM_W-1:0] sum_d, sum_q;
  logic [TOT_W-1:0] tot1_q;

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < cpl_pkg::NUM_LANES; l++) begin
      sum_d = sum_d + SUM_W'(mag_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      sum_q  <= sum_d;
      tot1_q <= tot0_q;
    end
  end

  // Divide stages: scale flag and divisor travel with the lanes
  logic             scale_q [QB];
  logic [SUM_W-1:0] den_q   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_carry
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (ld_i[2]) begin
          scale_q[0] <= (CMP_W'(sum_q) > CMP_W'(tot1_q));
          den_q[0]   <= sum_q;
        end
      end
      assign den_o[0] = sum_q;
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (ld_i[2+j]) begin
          scale_q[j] <= scale_q[j-1];
          den_q[j]   <= den_q[j-1];
        end
      end
      assign den_o[j] = den_q[j-1];
    end
  end

  assign scale_o = scale_q[QB-1];

endmodule
`default_nettype wire

// ----- hdl/chassis_current_power_limiter_top.sv -----
// Top level of the chassis current power limiter: stream ports, config registers, pipeline.
//
//  Channel   Direction  Request handshake            Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  four wheel commands, buffer, flags
//  m_axis    out        m_axis_tvalid/m_axis_tready  four limited wheel currents
//  cfg       in         cfg_valid_i/cfg_ready_o      register index, write data
//
//  One request per cycle is accepted while the pipeline is moving; the stages are clamp,
//  multiply, one pipeline stage per quotient bit of the per-lane restoring divider, output.
//  Every stage has its own valid bit and loads when the stage below is empty or moving,
//  so bubbles close up and a stalled output only stops the stages behind it once full.
//  Reset clears the valid bits and loads default limits; cfg_ready_o is always high.
`default_nettype none
module chassis_current_power_limiter_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tdata: front_left_in[15:0], front_right_in[31:16], back_left_in[47:32],
  //        back_right_in[63:48], power_buffer[79:64], referee_offline[80],
  //        boost_mode[81], zero pad[87:82]
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [cpl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tdata: front_left_out[15:0], front_right_out[31:16], back_left_out[47:32],
  //        back_right_out[63:48]
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [cpl_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cpl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [cpl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CUR_W     = cpl_pkg::CUR_W;
  localparam int NUM_LANES = cpl_pkg::NUM_LANES;
  localparam int N_ST      = cpl_pkg::N_ST;
  localparam int BUF_LSB   = NUM_LANES * CUR_W;

  // Configuration registers
  cpl_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_high <= cpl_pkg::RST_TOTAL_HIGH;
      cfg_q.total_mid  <= cpl_pkg::RST_TOTAL_MID;
      cfg_q.total_low  <= cpl_pkg::RST_TOTAL_LOW;
      cfg_q.wheel_high <= cpl_pkg::RST_WHEEL_HIGH;
      cfg_q.wheel_mid  <= cpl_pkg::RST_WHEEL_MID;
      cfg_q.wheel_low  <= cpl_pkg::RST_WHEEL_LOW;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cpl_pkg::cfg_reg_e'(cfg_index_i))
        cpl_pkg::REG_TOTAL_HIGH: cfg_q.total_high <= cfg_data_i;
        cpl_pkg::REG_TOTAL_MID:  cfg_q.total_mid  <= cfg_data_i;
        cpl_pkg::REG_TOTAL_LOW:  cfg_q.total_low  <= cfg_data_i;
        cpl_pkg::REG_WHEEL_HIGH: cfg_q.wheel_high <= cfg_data_i[cpl_pkg::WHL_W-1:0];
        cpl_pkg::REG_WHEEL_MID:  cfg_q.wheel_mid  <= cfg_data_i[cpl_pkg::WHL_W-1:0];
        cpl_pkg::REG_WHEEL_LOW:  cfg_q.wheel_low  <= cfg_data_i[cpl_pkg::WHL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: per-stage valid, ready ripples back from the output
  logic [N_ST-1:0] vld_q, vld_d;
  logic [N_ST:0]   rdy;

  always_comb begin
    rdy[N_ST] = m_axis_tready;
    for (int k = N_ST - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
    vld_d = vld_q;
    for (int k = 0; k < N_ST; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[N_ST-1];

  // Limit selection on the incoming request
  cpl_pkg::lim_t lim;

  cpl_tier_sel u_tier_sel (
    .buffer_i  (s_axis_tdata[BUF_LSB +: cpl_pkg::BUF_W]),
    .offline_i (s_axis_tdata[BUF_LSB + cpl_pkg::BUF_W]),
    .boost_i   (s_axis_tdata[BUF_LSB + cpl_pkg::BUF_W + 1]),
    .cfg_i     (cfg_q),
    .lim_o     (lim)
  );

  // Lanes and merge
  logic [NUM_LANES-1:0][CUR_W-1:0]                  mag, res;
  logic [cpl_pkg::TOT_W-1:0]                        tot0;
  logic [cpl_pkg::QB-1:0][cpl_pkg::SUM_W-1:0]       den;
  logic                                             scale;

  // Merge has no output register of its own, so it takes every load enable but the last
  cpl_merge u_merge (
    .clk_i   (clk_i),
    .ld_i    (rdy[N_ST-2:0]),
    .tot_i   (lim.total),
    .mag_i   (mag),
    .tot0_o  (tot0),
    .den_o   (den),
    .scale_o (scale)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    cpl_lane u_lane (
      .clk_i   (clk_i),
      .ld_i    (rdy[N_ST-1:0]),
      .cmd_i   (signed'(s_axis_tdata[l*CUR_W +: CUR_W])),
      .wheel_i (lim.wheel),
      .tot0_i  (tot0),
      .den_i   (den),
      .scale_i (scale),
      .mag_o   (mag[l]),
      .res_o   (res[l])
    );
  end

  assign m_axis_tdata = cpl_pkg::OUT_TDATA_W'(res);

endmodule
`default_nettype wire
